// ===== hdl/cot_pkg.sv =====
// ----------------------------------------------------------------------------
// cot_pkg
// Shared types, widths and constants of the capsule overlap test.
// ----------------------------------------------------------------------------
package cot_pkg;

    // coordinate format
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 12;
    localparam int RAD_W      = COORD_BITS - 1;

    // datapath widths
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int HALF_W     = DOT_W / 2;
    localparam int WIDE_W     = 2 * DOT_W + 2;

    // segment parameter format and divider
    localparam int PARAM_FRAC = 32;
    localparam int SC_W       = PARAM_FRAC + 1;
    localparam int Q_W        = PARAM_FRAC + 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_LAT    = DIV_STEPS + 1;

    // closest point and distance
    localparam int T_W        = DIFF_W + 3;
    localparam int SQ_W       = 2 * T_W;
    localparam int ACC_W      = SQ_W + 2;
    localparam int DIST_W     = 60;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // configuration port
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 5;
    localparam int IDX_W      = 3;
    localparam logic [IDX_W-1:0] REG_START_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_X      = 3'd3;
    localparam logic [IDX_W-1:0] REG_END_Y      = 3'd4;
    localparam logic [IDX_W-1:0] REG_END_Z      = 3'd5;
    localparam logic [IDX_W-1:0] REG_RADIUS     = 3'd6;
    localparam logic [IDX_W-1:0] NUM_COORD_REGS = 3'd6;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [RAD_W-1:0]      rad_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic signed [WIDE_W-1:0]     wide_t;
    typedef logic        [SC_W-1:0]       param_t;
    typedef logic        [DIST_W-1:0]     dist_t;

    typedef coord_t [2:0] coordvec_t;
    typedef diff_t  [2:0] vec_t;

    // segment directions, start offset and probe radius
    typedef struct packed {
        vec_t u;
        vec_t v;
        vec_t w;
        rad_t prad;
    } geo_t;

    typedef struct packed {
        dot_t a;
        dot_t b;
        dot_t c;
        dot_t d;
        dot_t e;
    } dots_t;

    // one classified request waiting for the back end
    typedef struct packed {
        geo_t  geo;
        wide_t sn;
        wide_t sd;
        wide_t tn;
        wide_t td;
    } entry_t;

    // smallest Q.48 determinant that counts as non-parallel
    localparam wide_t PAR_LIMIT = wide_t'(
        ((64'd1 << (4 * FRAC_BITS)) - 64'd1) / 64'd1000000000 + 64'd1);

endpackage

// ===== hdl/cot_if.sv =====
// ----------------------------------------------------------------------------
// cot_if
// Request and result channels of the capsule overlap test.
// ----------------------------------------------------------------------------
interface cot_probe_if;
    logic           valid;
    logic           ready;
    cot_pkg::coord_t probe_start_x;
    cot_pkg::coord_t probe_start_y;
    cot_pkg::coord_t probe_start_z;
    cot_pkg::coord_t probe_end_x;
    cot_pkg::coord_t probe_end_y;
    cot_pkg::coord_t probe_end_z;
    cot_pkg::rad_t   probe_radius;

    modport source (
        output valid, probe_start_x, probe_start_y, probe_start_z,
               probe_end_x, probe_end_y, probe_end_z, probe_radius,
        input  ready
    );
    modport sink (
        input  valid, probe_start_x, probe_start_y, probe_start_z,
               probe_end_x, probe_end_y, probe_end_z, probe_radius,
        output ready
    );
endinterface

interface cot_result_if;
    logic           valid;
    logic           ready;
    logic           hit;
    cot_pkg::dist_t closest_dist_sq;

    modport source (
        output valid, hit, closest_dist_sq,
        input  ready
    );
    modport sink (
        input  valid, hit, closest_dist_sq,
        output ready
    );
endinterface

// ===== hdl/cot_wmul.sv =====
// ----------------------------------------------------------------------------
// cot_wmul
// Two-stage signed multiplier for dot products, built from four half-width
// partial products.
// ----------------------------------------------------------------------------
module cot_wmul (
    input  logic          clk,
    input  logic          en,
    input  cot_pkg::dot_t x,
    input  cot_pkg::dot_t y,
    output cot_pkg::wide_t p
);
    localparam int HI_W = cot_pkg::DOT_W - cot_pkg::HALF_W;

    logic signed [HI_W-1:0]               xh, yh;
    logic        [cot_pkg::HALF_W-1:0]    xl, yl;
    logic signed [2*HI_W-1:0]             hh_reg;
    logic signed [HI_W+cot_pkg::HALF_W:0] hl_reg;
    logic signed [HI_W+cot_pkg::HALF_W:0] lh_reg;
    logic        [2*cot_pkg::HALF_W-1:0]  ll_reg;
    cot_pkg::wide_t                       p_reg;

    // split into signed high and unsigned low halves
    assign xh = x[cot_pkg::DOT_W-1:cot_pkg::HALF_W];
    assign yh = y[cot_pkg::DOT_W-1:cot_pkg::HALF_W];
    assign xl = x[cot_pkg::HALF_W-1:0];
    assign yl = y[cot_pkg::HALF_W-1:0];

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= xh * yh;
            hl_reg <= xh * $signed({1'b0, yl});
            lh_reg <= yh * $signed({1'b0, xl});
            ll_reg <= xl * yl;
        end
    end

    // recombine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (cot_pkg::wide_t'(hh_reg) <<< (2 * cot_pkg::HALF_W))
                   + ((cot_pkg::wide_t'(hl_reg) + cot_pkg::wide_t'(lh_reg))
                      <<< cot_pkg::HALF_W)
                   + cot_pkg::wide_t'(ll_reg);
        end
    end

    assign p = p_reg;

endmodule

// ===== hdl/cot_fifo.sv =====
// ----------------------------------------------------------------------------
// cot_fifo
// Short queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module cot_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cot_pkg::entry_t din,
    output logic            full,
    input  logic            pop,
    output cot_pkg::entry_t dout,
    output logic            empty
);
    cot_pkg::entry_t               mem [cot_pkg::FIFO_DEPTH];
    logic [cot_pkg::PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [cot_pkg::CNT_W-1:0]     count_reg;

    assign full  = (count_reg == cot_pkg::CNT_W'(cot_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill level, depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fill level lost a request");

endmodule

// ===== hdl/cot_div.sv =====
// ----------------------------------------------------------------------------
// cot_div
// Pipelined restoring divider giving a rounded quotient in [0,1], one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module cot_div (
    input  logic            clk,
    input  logic            en,
    input  cot_pkg::wide_t  num,
    input  cot_pkg::wide_t  den,
    output cot_pkg::param_t quo
);
    localparam int N = cot_pkg::DIV_STEPS;

    logic [cot_pkg::WIDE_W-1:0] r_reg    [0:N];
    logic [cot_pkg::WIDE_W-1:0] d_reg    [0:N];
    logic [cot_pkg::Q_W-1:0]    q_reg    [0:N];
    logic                       zero_reg [0:N];
    logic                       one_reg  [0:N];
    logic [cot_pkg::Q_W:0]      rounded;

    // special cases: non-positive operands and a quotient of one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (den <= cot_pkg::wide_t'(0)) || (num <= cot_pkg::wide_t'(0));
            one_reg[0]  <= (num >= den);
            r_reg[0]    <= num;
            d_reg[0]    <= den;
            q_reg[0]    <= '0;
        end
    end

    // one compare and subtract per stage
    for (genvar i = 1; i <= N; i++)
    begin : g_step
        logic                       ge;
        logic [cot_pkg::WIDE_W-1:0] rem;

        assign ge  = (r_reg[i-1] >= d_reg[i-1]);
        assign rem = ge ? (r_reg[i-1] - d_reg[i-1]) : r_reg[i-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]    <= {rem[cot_pkg::WIDE_W-2:0], 1'b0};
                d_reg[i]    <= d_reg[i-1];
                q_reg[i]    <= {q_reg[i-1][cot_pkg::Q_W-2:0], ge};
                zero_reg[i] <= zero_reg[i-1];
                one_reg[i]  <= one_reg[i-1];
            end
        end
    end

    // round half up, drop the guard bit
    assign rounded = {1'b0, q_reg[N]} + 1'b1;

    always_comb
    begin
        priority if (zero_reg[N])
        begin
            quo = '0;
        end
        else if (one_reg[N])
        begin
            quo = cot_pkg::param_t'(1) << cot_pkg::PARAM_FRAC;
        end
        else
        begin
            quo = rounded[cot_pkg::SC_W:1];
        end
    end

endmodule

// ===== hdl/cot_front.sv =====
// ----------------------------------------------------------------------------
// cot_front
// Front end: takes probe capsules, forms the dot products and numerators and
// settles the clamping case of each request.
// ----------------------------------------------------------------------------
module cot_front (
    input  logic               clk,
    input  logic               rst_n,
    cot_probe_if.sink          probe,
    input  cot_pkg::coordvec_t ref_start,
    input  cot_pkg::coordvec_t ref_end,
    input  logic               queue_full,
    output logic               push,
    output cot_pkg::entry_t    entry
);
    localparam int LAST = 8;

    logic               en;
    logic               valid_reg [1:LAST];
    cot_pkg::coordvec_t ps, pe;
    cot_pkg::geo_t      geo_next;
    cot_pkg::geo_t      geo_reg  [1:LAST];
    cot_pkg::prod_t     uu_reg [3], uv_reg [3], vv_reg [3], uw_reg [3], vw_reg [3];
    cot_pkg::dots_t     dots_reg [3:7];
    cot_pkg::wide_t     p_ac, p_bb, p_be, p_cd, p_ae, p_bd;
    cot_pkg::wide_t     dd6_reg, sn6_reg, tn6_reg;
    cot_pkg::wide_t     sn7_next, sd7_next, tn7_next, td7_next;
    cot_pkg::wide_t     sn7_reg, sd7_reg, tn7_reg, td7_reg;
    cot_pkg::wide_t     sn8_next, sd8_next, tn8_next, td8_next, nd;
    cot_pkg::wide_t     sn8_reg, sd8_reg, tn8_reg, td8_reg;
    logic               clamp;

    // the pipeline moves whenever its last request can leave
    assign en          = !valid_reg[LAST] || !queue_full;
    assign probe.ready = en;
    assign push        = valid_reg[LAST] && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAST; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[1] <= probe.valid;
            for (int i = 2; i <= LAST; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // segment differences
    assign ps = {probe.probe_start_z, probe.probe_start_y, probe.probe_start_x};
    assign pe = {probe.probe_end_z, probe.probe_end_y, probe.probe_end_x};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            geo_next.u[k] = cot_pkg::DIFF_W'($signed(ref_end[k]))
                          - cot_pkg::DIFF_W'($signed(ref_start[k]));
            geo_next.v[k] = cot_pkg::DIFF_W'($signed(pe[k]))
                          - cot_pkg::DIFF_W'($signed(ps[k]));
            geo_next.w[k] = cot_pkg::DIFF_W'($signed(ref_start[k]))
                          - cot_pkg::DIFF_W'($signed(ps[k]));
        end
        geo_next.prad = probe.probe_radius;
    end

    // geometry travels alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[1] <= geo_next;
            for (int i = 2; i <= LAST; i++)
            begin
                geo_reg[i] <= geo_reg[i-1];
            end
        end
    end

    // component products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                uu_reg[k] <= $signed(geo_reg[1].u[k]) * $signed(geo_reg[1].u[k]);
                uv_reg[k] <= $signed(geo_reg[1].u[k]) * $signed(geo_reg[1].v[k]);
                vv_reg[k] <= $signed(geo_reg[1].v[k]) * $signed(geo_reg[1].v[k]);
                uw_reg[k] <= $signed(geo_reg[1].u[k]) * $signed(geo_reg[1].w[k]);
                vw_reg[k] <= $signed(geo_reg[1].v[k]) * $signed(geo_reg[1].w[k]);
            end
        end
    end

    // dot products, then carried along
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dots_reg[3].a <= cot_pkg::DOT_W'(uu_reg[0]) + cot_pkg::DOT_W'(uu_reg[1])
                           + cot_pkg::DOT_W'(uu_reg[2]);
            dots_reg[3].b <= cot_pkg::DOT_W'(uv_reg[0]) + cot_pkg::DOT_W'(uv_reg[1])
                           + cot_pkg::DOT_W'(uv_reg[2]);
            dots_reg[3].c <= cot_pkg::DOT_W'(vv_reg[0]) + cot_pkg::DOT_W'(vv_reg[1])
                           + cot_pkg::DOT_W'(vv_reg[2]);
            dots_reg[3].d <= cot_pkg::DOT_W'(uw_reg[0]) + cot_pkg::DOT_W'(uw_reg[1])
                           + cot_pkg::DOT_W'(uw_reg[2]);
            dots_reg[3].e <= cot_pkg::DOT_W'(vw_reg[0]) + cot_pkg::DOT_W'(vw_reg[1])
                           + cot_pkg::DOT_W'(vw_reg[2]);
            for (int i = 4; i <= 7; i++)
            begin
                dots_reg[i] <= dots_reg[i-1];
            end
        end
    end

    // wide products for determinant and numerators
    cot_wmul u_mul_ac (.clk(clk), .en(en), .x(dots_reg[3].a), .y(dots_reg[3].c), .p(p_ac));
    cot_wmul u_mul_bb (.clk(clk), .en(en), .x(dots_reg[3].b), .y(dots_reg[3].b), .p(p_bb));
    cot_wmul u_mul_be (.clk(clk), .en(en), .x(dots_reg[3].b), .y(dots_reg[3].e), .p(p_be));
    cot_wmul u_mul_cd (.clk(clk), .en(en), .x(dots_reg[3].c), .y(dots_reg[3].d), .p(p_cd));
    cot_wmul u_mul_ae (.clk(clk), .en(en), .x(dots_reg[3].a), .y(dots_reg[3].e), .p(p_ae));
    cot_wmul u_mul_bd (.clk(clk), .en(en), .x(dots_reg[3].b), .y(dots_reg[3].d), .p(p_bd));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd6_reg <= p_ac - p_bb;
            sn6_reg <= p_be - p_cd;
            tn6_reg <= p_ae - p_bd;
        end
    end

    // near-parallel case and clamp of the reference parameter
    always_comb
    begin
        sn7_next = sn6_reg;
        sd7_next = dd6_reg;
        tn7_next = tn6_reg;
        td7_next = dd6_reg;
        priority if (dd6_reg < cot_pkg::PAR_LIMIT)
        begin
            sn7_next = '0;
            sd7_next = cot_pkg::wide_t'(1);
            tn7_next = cot_pkg::WIDE_W'(dots_reg[6].e);
            td7_next = cot_pkg::WIDE_W'(dots_reg[6].c);
        end
        else if (sn6_reg < cot_pkg::wide_t'(0))
        begin
            sn7_next = '0;
            tn7_next = cot_pkg::WIDE_W'(dots_reg[6].e);
            td7_next = cot_pkg::WIDE_W'(dots_reg[6].c);
        end
        else if (sn6_reg > dd6_reg)
        begin
            sn7_next = dd6_reg;
            tn7_next = cot_pkg::WIDE_W'(dots_reg[6].e) + cot_pkg::WIDE_W'(dots_reg[6].b);
            td7_next = cot_pkg::WIDE_W'(dots_reg[6].c);
        end
        else
        begin
            // reference parameter already within the segment
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn7_reg <= sn7_next;
            sd7_reg <= sd7_next;
            tn7_reg <= tn7_next;
            td7_reg <= td7_next;
        end
    end

    // clamp of the probe parameter, reference parameter recomputed over a
    always_comb
    begin
        sn8_next = sn7_reg;
        sd8_next = sd7_reg;
        tn8_next = tn7_reg;
        td8_next = td7_reg;
        nd       = '0;
        clamp    = 1'b0;
        priority if (tn7_reg < cot_pkg::wide_t'(0))
        begin
            tn8_next = '0;
            nd       = -cot_pkg::WIDE_W'(dots_reg[7].d);
            clamp    = 1'b1;
        end
        else if (tn7_reg > td7_reg)
        begin
            tn8_next = td7_reg;
            nd       = cot_pkg::WIDE_W'(dots_reg[7].b) - cot_pkg::WIDE_W'(dots_reg[7].d);
            clamp    = 1'b1;
        end
        else
        begin
            // probe parameter already within the segment
        end
        if (clamp)
        begin
            priority if (nd < cot_pkg::wide_t'(0))
            begin
                sn8_next = '0;
            end
            else if (nd > cot_pkg::WIDE_W'(dots_reg[7].a))
            begin
                sn8_next = sd7_reg;
            end
            else
            begin
                sn8_next = nd;
                sd8_next = cot_pkg::WIDE_W'(dots_reg[7].a);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn8_reg <= sn8_next;
            sd8_reg <= sd8_next;
            tn8_reg <= tn8_next;
            td8_reg <= td8_next;
        end
    end

    assign entry = '{geo: geo_reg[LAST], sn: sn8_reg, sd: sd8_reg, tn: tn8_reg, td: td8_reg};

endmodule

// ===== hdl/cot_back.sv =====
// ----------------------------------------------------------------------------
// cot_back
// Back end: divides out both segment parameters, builds the closest-point
// offset and gives the squared distance and the hit flag.
// ----------------------------------------------------------------------------
module cot_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cot_pkg::entry_t head,
    input  logic            queue_empty,
    output logic            pop,
    input  cot_pkg::rad_t   ref_radius,
    cot_result_if.source    result
);
    localparam int DL   = cot_pkg::DIV_LAT;
    localparam int LAST = DL + 3;
    localparam int SP_W = cot_pkg::SC_W + 1 + cot_pkg::DIFF_W;
    localparam int TS_W = SP_W + 1;

    typedef logic signed [SP_W-1:0] sp_t;
    typedef logic signed [TS_W-1:0] ts_t;

    localparam ts_t ROUND_C = ts_t'(1) <<< (cot_pkg::PARAM_FRAC - 1);

    logic                            en;
    logic                            valid_reg [0:LAST];
    cot_pkg::geo_t                   geo_reg   [0:DL-1];
    cot_pkg::param_t                 sc, tc;
    sp_t                             su_reg [3], tv_reg [3];
    cot_pkg::diff_t                  w_reg  [3];
    cot_pkg::rad_t                   prad_reg;
    ts_t                             ts     [3];
    logic signed [cot_pkg::T_W-1:0]  t_reg  [3];
    logic [cot_pkg::COORD_BITS-1:0]  rs_reg;
    logic signed [cot_pkg::SQ_W-1:0] sq_reg [3];
    logic [2*cot_pkg::COORD_BITS-1:0] rsq_reg;
    logic [cot_pkg::ACC_W-1:0]       acc;
    logic                            hit_reg;
    cot_pkg::dist_t                  dist_reg;

    // the pipeline moves whenever its result can leave
    assign en           = !valid_reg[LAST] || result.ready;
    assign pop          = en && !queue_empty;
    assign result.valid = valid_reg[LAST];
    assign result.hit   = hit_reg;
    assign result.closest_dist_sq = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= !queue_empty;
            for (int i = 1; i <= LAST; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // parameter dividers
    cot_div u_sdiv (.clk(clk), .en(en), .num(head.sn), .den(head.sd), .quo(sc));
    cot_div u_tdiv (.clk(clk), .en(en), .num(head.tn), .den(head.td), .quo(tc));

    // geometry follows the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= head.geo;
            for (int i = 1; i < DL; i++)
            begin
                geo_reg[i] <= geo_reg[i-1];
            end
        end
    end

    // scaled direction vectors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                su_reg[k] <= $signed({1'b0, sc}) * $signed(geo_reg[DL-1].u[k]);
                tv_reg[k] <= $signed({1'b0, tc}) * $signed(geo_reg[DL-1].v[k]);
                w_reg[k]  <= geo_reg[DL-1].w[k];
            end
            prad_reg <= geo_reg[DL-1].prad;
        end
    end

    // offset between closest points, rounded to the coordinate grid
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ts[k] = (ts_t'(w_reg[k]) <<< cot_pkg::PARAM_FRAC) + ts_t'(su_reg[k])
                  - ts_t'(tv_reg[k]) + ROUND_C;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                t_reg[k] <= ts[k][cot_pkg::PARAM_FRAC +: cot_pkg::T_W];
            end
            rs_reg <= cot_pkg::COORD_BITS'(prad_reg) + cot_pkg::COORD_BITS'(ref_radius);
        end
    end

    // squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= t_reg[k] * t_reg[k];
            end
            rsq_reg <= rs_reg * rs_reg;
        end
    end

    // distance sum, hit test and saturation
    assign acc = cot_pkg::ACC_W'($unsigned(sq_reg[0])) + cot_pkg::ACC_W'($unsigned(sq_reg[1]))
               + cot_pkg::ACC_W'($unsigned(sq_reg[2]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= (acc < rsq_reg);
            dist_reg <= (|(acc >> cot_pkg::DIST_W)) ? '1 : cot_pkg::DIST_W'(acc);
        end
    end

endmodule

// ===== hdl/capsule_overlap_test.sv =====
// ----------------------------------------------------------------------------
// capsule_overlap_test
// Throughput: one request per cycle while neither pipe stalls, set by the fully pipelined dividers.
// The front pipe and back pipe stall on their own across a 4-entry queue.
// Reset clears all valid bits, the queue and the reference registers to 0.
// Segment parameter dividers take one quotient bit per stage.
// ----------------------------------------------------------------------------
module capsule_overlap_test (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cot_pkg::ADDR_W-1:0]   paddr,
    input  logic [cot_pkg::DATA_W-1:0]   pwdata,
    output logic [cot_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    cot_probe_if.sink                    probe,
    cot_result_if.source                 result
);
    cot_pkg::coord_t            coord_reg [cot_pkg::NUM_COORD_REGS];
    cot_pkg::rad_t              radius_reg;
    logic [cot_pkg::IDX_W-1:0]  idx;
    logic                       wr;
    cot_pkg::coordvec_t         ref_start, ref_end;
    logic                       push, pop, full, empty;
    cot_pkg::entry_t            q_in, q_out;

    // register file
    assign pready = 1'b1;
    assign idx    = paddr[cot_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cot_pkg::NUM_COORD_REGS; i++)
            begin
                coord_reg[i] <= '0;
            end
            radius_reg <= '0;
        end
        else if (wr)
        begin
            priority if (idx < cot_pkg::NUM_COORD_REGS)
            begin
                coord_reg[idx] <= pwdata[cot_pkg::COORD_BITS-1:0];
            end
            else if (idx == cot_pkg::REG_RADIUS)
            begin
                radius_reg <= pwdata[cot_pkg::RAD_W-1:0];
            end
            else
            begin
                // unmapped index, write ignored
            end
        end
    end

    // read back
    always_comb
    begin
        priority if (idx < cot_pkg::NUM_COORD_REGS)
        begin
            prdata = cot_pkg::DATA_W'($unsigned(coord_reg[idx]));
        end
        else if (idx == cot_pkg::REG_RADIUS)
        begin
            prdata = cot_pkg::DATA_W'(radius_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign ref_start = {coord_reg[cot_pkg::REG_START_Z], coord_reg[cot_pkg::REG_START_Y],
                        coord_reg[cot_pkg::REG_START_X]};
    assign ref_end   = {coord_reg[cot_pkg::REG_END_Z], coord_reg[cot_pkg::REG_END_Y],
                        coord_reg[cot_pkg::REG_END_X]};

    // front end
    cot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .probe      (probe),
        .ref_start  (ref_start),
        .ref_end    (ref_end),
        .queue_full (full),
        .push       (push),
        .entry      (q_in)
    );

    // queue
    cot_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_in),
        .full  (full),
        .pop   (pop),
        .dout  (q_out),
        .empty (empty)
    );

    // back end
    cot_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_out),
        .queue_empty (empty),
        .pop         (pop),
        .ref_radius  (radius_reg),
        .result      (result)
    );

endmodule
